FILE: src/mssd_pkg.sv
package mssd_pkg;

   localparam int ValueWidth = 16;
   localparam int CodeWidth = 4;
   localparam int MagWidth = 10;
   localparam int SegWidth = 7;
   localparam int DigitPinWidth = 3;

   localparam logic [ValueWidth-1:0] SENTINEL_VALUE = 16'd12345;
   localparam logic [MagWidth-1:0] MAX_MAGNITUDE = 10'd999;
   localparam logic [CodeWidth-1:0] DASH_CODE = 4'd10;

   // active-low digit enables
   localparam logic [DigitPinWidth-1:0] DIGIT_UNITS_ON = 3'b110;
   localparam logic [DigitPinWidth-1:0] DIGIT_TENS_ON = 3'b101;
   localparam logic [DigitPinWidth-1:0] DIGIT_HUNDREDS_ON = 3'b011;
   localparam logic [DigitPinWidth-1:0] DIGIT_ALL_OFF = 3'b111;

   localparam logic [SegWidth-1:0] SEG_ZERO = 7'h3F;
   localparam logic [SegWidth-1:0] SEG_DASH = 7'h40;

   typedef struct packed {
      logic negative;
      logic [CodeWidth-1:0] hundreds;
      logic [CodeWidth-1:0] tens;
      logic [CodeWidth-1:0] units;
   } digit_type;

   function automatic logic [SegWidth-1:0] seg_pattern(input logic [CodeWidth-1:0] code);
      logic [SegWidth-1:0] pattern;
      case (code)
         4'd0: pattern = SEG_ZERO;
         4'd1: pattern = 7'h06;
         4'd2: pattern = 7'h5B;
         4'd3: pattern = 7'h4F;
         4'd4: pattern = 7'h66;
         4'd5: pattern = 7'h6D;
         4'd6: pattern = 7'h7D;
         4'd7: pattern = 7'h07;
         4'd8: pattern = 7'h7F;
         4'd9: pattern = 7'h6F;
         default: pattern = SEG_DASH;
      endcase
      return pattern;
   endfunction

endpackage

FILE: src/mux_seven_segment_display.sv
// three-digit multiplexed seven-segment display driver
// each transfer on the req_ channel is one refresh tick carrying a signed
// value and the run_mode and show_temp flags; each tick gives exactly one
// transfer on the rsp_ channel with the segment pattern, the active-low digit
// enables and the decimal point of the digit scanned on that tick
// digits scan hundreds, tens, units and repeat; a zero hundreds digit is
// blanked, 12345 shows dashes, magnitudes above 999 show as 999
// on the tens digit in run mode with temperature display a negative value
// blinks the point, toggling every BLINK_SCANS such scans
// a req_ transfer passes through an input register then a result register,
// with the digit split and segment decode between
// throughput is one tick per cycle while rsp_stall is low; a new tick is
// taken while a result waits in the result register, and req_stall rises
// only when both registers are full and rsp_stall is high
// a synchronous reset empties both registers, restarts the scan at the
// hundreds digit and clears the blink counter and phase
module mux_seven_segment_display
   import mssd_pkg::*;
#(
   parameter int BLINK_SCANS = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [ValueWidth-1:0] req_value,
   input  logic                        req_run_mode,
   input  logic                        req_show_temp,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [SegWidth-1:0]         rsp_segment_pins,
   output logic [DigitPinWidth-1:0]    rsp_digit_pins,
   output logic                        rsp_point_pin
);

   localparam int CountWidth = $clog2(BLINK_SCANS + 1);
   localparam logic [CountWidth-1:0] CountLast = CountWidth'(BLINK_SCANS);

   typedef enum logic [1:0] {
      SCAN_UNITS    = 2'd0,
      SCAN_TENS     = 2'd1,
      SCAN_HUNDREDS = 2'd2
   } scan_type;

   logic                         in_valid_ff, in_valid_in;
   logic signed [ValueWidth-1:0] in_value_ff;
   logic                         in_run_ff;
   logic                         in_temp_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [SegWidth-1:0]          seg_ff, seg_in;
   logic [DigitPinWidth-1:0]     dig_ff, dig_in;
   logic                         point_ff, point_in;
   scan_type                     scan_ff, scan_in;
   logic [CountWidth-1:0]        count_ff, count_in;
   logic                         phase_ff, phase_in;
   logic [CountWidth-1:0]        count_next;
   logic                         req_take;
   logic                         advance;
   digit_type                    digits;

   mssd_digit_split u_split (
      .value  (in_value_ff),
      .digits (digits)
   );

   assign advance = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;
   assign count_next = count_ff + 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      scan_in = scan_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      seg_in = seg_ff;
      dig_in = dig_ff;
      point_in = point_ff;
      if (advance) begin
         unique case (scan_ff)
            SCAN_TENS: begin
               dig_in = DIGIT_TENS_ON;
               seg_in = seg_pattern(digits.tens);
               point_in = 1'b0;
               if (in_run_ff && in_temp_ff) begin
                  if (digits.negative) begin
                     // minus sign blink
                     if (count_next == CountLast) begin
                        count_in = '0;
                        phase_in = !phase_ff;
                     end else begin
                        count_in = count_next;
                     end
                     point_in = !phase_in;
                  end else begin
                     point_in = 1'b1;
                  end
               end
               scan_in = SCAN_UNITS;
            end
            SCAN_UNITS: begin
               dig_in = DIGIT_UNITS_ON;
               seg_in = seg_pattern(digits.units);
               point_in = 1'b0;
               scan_in = SCAN_HUNDREDS;
            end
            default: begin
               dig_in = (digits.hundreds == '0) ? DIGIT_ALL_OFF : DIGIT_HUNDREDS_ON;
               seg_in = seg_pattern(digits.hundreds);
               point_in = 1'b0;
               scan_in = SCAN_TENS;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_ff <= SCAN_HUNDREDS;
         count_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff <= scan_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_value_ff <= req_value;
         in_run_ff <= req_run_mode;
         in_temp_ff <= req_show_temp;
      end
      seg_ff <= seg_in;
      dig_ff <= dig_in;
      point_ff <= point_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_segment_pins = seg_ff;
   assign rsp_digit_pins = dig_ff;
   assign rsp_point_pin = point_ff;

   a_reset_scan: assert property (@(posedge clock) reset |=> scan_ff == SCAN_HUNDREDS)
      else $error("scan does not restart at hundreds after reset");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      advance && scan_ff == SCAN_TENS |=> scan_ff == SCAN_UNITS)
      else $error("tens scan not followed by units");

   a_point_tens: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && point_ff |-> dig_ff == DIGIT_TENS_ON)
      else $error("point lit outside tens digit");

   a_blank_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && dig_ff == DIGIT_ALL_OFF |-> seg_ff == SEG_ZERO)
      else $error("blanked digit not a zero hundreds");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < CountLast)
      else $error("blink counter out of range");

endmodule

FILE: src/mssd_digit_split.sv
module mssd_digit_split
   import mssd_pkg::*;
(
   input  logic signed [ValueWidth-1:0] value,
   output digit_type                    digits
);

   logic [ValueWidth-1:0] raw;
   logic                  negative;
   logic [ValueWidth-1:0] mag_full;
   logic [MagWidth-1:0]   mag;
   logic [15:0]           hund_prod;
   logic [CodeWidth-1:0]  hundreds;
   logic [MagWidth-1:0]   rem_wide;
   logic [6:0]            rem;
   logic [14:0]           tens_prod;
   logic [CodeWidth-1:0]  tens;
   logic [6:0]            units_wide;

   assign raw = value;
   assign negative = raw[ValueWidth-1];
   assign mag_full = negative ? (~raw + 16'd1) : raw;
   assign mag = (mag_full > 16'(MAX_MAGNITUDE)) ? MAX_MAGNITUDE : mag_full[MagWidth-1:0];

   // divide by 100 and by 10 through reciprocal multiplies, exact below 1000
   assign hund_prod = 16'(mag) * 16'd41;
   assign hundreds = hund_prod[15:12];
   assign rem_wide = mag - (10'(hundreds) * 10'd100);
   assign rem = rem_wide[6:0];
   assign tens_prod = 15'(rem) * 15'd205;
   assign tens = tens_prod[14:11];
   assign units_wide = rem - (7'(tens) * 7'd10);

   always_comb begin
      digits.negative = negative;
      if (raw == SENTINEL_VALUE) begin
         digits.hundreds = DASH_CODE;
         digits.tens = DASH_CODE;
         digits.units = DASH_CODE;
      end else begin
         digits.hundreds = hundreds;
         digits.tens = tens;
         digits.units = units_wide[CodeWidth-1:0];
      end
   end

endmodule
